@@ hw/rtl/sha1_pkg.sv @@
// shared constants, control structs and round functions of the sha-1 hasher
`default_nettype none

package sha1_pkg;

	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned ROUNDS       = 80;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// chaining word initial values, entry 0 is h0
	localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] LEN_FILL   = 6'd56;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
	localparam logic [2:0] WORD_LAST  = 3'(DIGEST_WORDS - 1);

	// control to the message schedule
	typedef struct packed {
		logic       put;
		logic [7:0] data;
		logic       shift;
	} sched_ctl_t;

	// control to the round unit
	typedef struct packed {
		logic       load;
		logic       step;
		logic       fold;
		logic       restart;
		logic [6:0] round;
	} round_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		logic [63:0] dbl;
		dbl = {v, v} << n;
		return dbl[63:32];
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) k = K_0;
		else if (r < 7'd40) k = K_1;
		else if (r < 7'd60) k = K_2;
		else k = K_3;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) f = (b & c) | (~b & d);
		else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha1_stream_if.sv @@
// valid/ready channel interfaces for message requests and digest words
`default_nettype none

interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source(output valid, output opcode, output data_byte, input ready);
	modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink(input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sha1_sched.sv @@
// block buffer as a byte shift line, reused as the 16-word schedule window
`default_nettype none

module sha1_sched
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire sched_ctl_t  ctl,
	output logic      [31:0] w_cur
);

	// word j of the window sits at bits 511-32j downto 480-32j
	logic [511:0] win_q;
	logic [31:0]  w_new;

	assign w_cur = win_q[511:480];
	assign w_new = rotl(win_q[511-32*13 -: 32] ^ win_q[511-32*8 -: 32]
		^ win_q[511-32*2 -: 32] ^ win_q[511:480], 1);

	always_ff @(posedge clk) begin
		if (ctl.put) begin
			win_q <= {win_q[503:0], ctl.data};
		end else if (ctl.shift) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sha1_round.sv @@
// working variables, one round per cycle, and the chaining words
`default_nettype none

module sha1_round
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire round_ctl_t  ctl,
	input  wire logic [31:0] w_cur,
	input  wire logic [2:0]  word_sel,
	output logic      [31:0] digest_word
);

	logic [DIGEST_WORDS-1:0][31:0] chain_q;
	logic [DIGEST_WORDS-1:0][31:0] var_q;   // a..e
	logic [31:0]                   t_sum;

	assign t_sum = rotl(var_q[0], 5) + round_f(ctl.round, var_q[1], var_q[2], var_q[3])
		+ var_q[4] + w_cur + round_k(ctl.round);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			var_q <= chain_q;
		end else if (ctl.step) begin
			var_q[0] <= t_sum;
			var_q[1] <= var_q[0];
			var_q[2] <= rotl(var_q[1], 30);
			var_q[3] <= var_q[2];
			var_q[4] <= var_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
		end else if (ctl.restart) begin
			chain_q <= H_INIT;
		end else if (ctl.fold) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + var_q[i];
			end
		end
	end

	always_comb begin
		case (word_sel)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			default: digest_word = chain_q[4];
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/sha1_stream_hasher.sv @@
// top level of the streaming sha-1 hasher: sequencer, padding and digest output
//
// usage
//   msg channel: one request per message byte (opcode absorb, data_byte) or a
//   finish request (opcode finish, data_byte ignored)
//   digest channel: after a finish, five words h0..h4 with word_index 0..4,
//   last_word set on the fifth
// timing
//   an absorb request is taken while the hasher is idle; the request that
//   fills the 64-byte block starts a compression (80 rounds on the one
//   shared round unit, then a fold into the chaining words), and msg.ready
//   is low meanwhile
//   finish: padding bytes (0x80, then zeros) up to the length field, a switch
//   to the length, 8 length bytes, a compression for each block that fills
//   (one or two blocks), then one digest word per cycle while not stalled
// reset and stalls
//   reset loads the initial chaining words and clears fill and byte counts;
//   the block buffer holds no reset value and is overwritten before use
//   a stalled digest word simply holds; no new request is taken until the
//   fifth word is taken, after which the hasher is back at its initial state
`default_nettype none

module sha1_stream_hasher
	import sha1_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sha1_in_if.sink    msg,
	sha1_out_if.source digest
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t      st_q;
	state_t      ret_q;        // where to go once the block is folded in
	logic [5:0]  fill_q;       // bytes held in the block buffer
	logic [31:0] count_q;      // message length in bytes, wraps
	logic [6:0]  round_q;
	logic [2:0]  idx_q;        // digest word being shown
	logic        first_q;      // next padding byte is the 0x80 marker
	logic [63:0] len_q;        // bit length, shifted out msb first

	sched_ctl_t  sc;
	round_ctl_t  rc;
	logic [31:0] w_cur;
	logic        msg_take;
	logic        word_take;
	logic        len_switch;

	assign msg.ready      = (st_q == ST_IDLE);
	assign msg_take       = msg.valid && msg.ready;
	assign digest.valid   = (st_q == ST_EMIT);
	assign word_take      = digest.valid && digest.ready;
	assign digest.word_index = idx_q;
	assign digest.last_word  = (idx_q == WORD_LAST);

	// padding zeros stop once the length field is reached
	assign len_switch = !first_q && (fill_q == LEN_FILL);

	always_comb begin
		sc = '0;
		case (st_q)
			ST_IDLE: begin
				if (msg_take && msg.opcode == OP_ABSORB) begin
					sc.put  = 1'b1;
					sc.data = msg.data_byte;
				end
			end
			ST_PAD: begin
				if (!len_switch) begin
					sc.put  = 1'b1;
					sc.data = first_q ? PAD_MARK : 8'h00;
				end
			end
			ST_LEN: begin
				sc.put  = 1'b1;
				sc.data = len_q[63:56];
			end
			ST_ROUND: sc.shift = 1'b1;
			default: sc = '0;
		endcase

		// a full block copies the chaining words into the working variables
		rc.load    = sc.put && (fill_q == FILL_LAST);
		rc.step    = (st_q == ST_ROUND);
		rc.fold    = (st_q == ST_FOLD);
		rc.restart = word_take && (idx_q == WORD_LAST);
		rc.round   = round_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ret_q   <= ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			round_q <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
		end else begin
			if (sc.put) begin
				fill_q <= fill_q + 6'd1;
			end
			case (st_q)
				ST_IDLE: begin
					if (msg_take) begin
						if (msg.opcode == OP_ABSORB) begin
							count_q <= count_q + 32'd1;
							if (fill_q == FILL_LAST) begin
								st_q  <= ST_ROUND;
								ret_q <= ST_IDLE;
							end
						end else begin
							first_q <= 1'b1;
							st_q    <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (len_switch) begin
						st_q <= ST_LEN;
					end else begin
						first_q <= 1'b0;
						if (fill_q == FILL_LAST) begin
							st_q  <= ST_ROUND;
							ret_q <= ST_PAD;
						end
					end
				end
				ST_LEN: begin
					if (fill_q == FILL_LAST) begin
						st_q  <= ST_ROUND;
						ret_q <= ST_EMIT;
					end
				end
				ST_ROUND: begin
					if (round_q == ROUND_LAST) begin
						round_q <= '0;
						st_q    <= ST_FOLD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_FOLD: begin
					round_q <= '0;
					idx_q   <= '0;
					st_q    <= ret_q;
				end
				ST_EMIT: begin
					if (word_take) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == WORD_LAST) begin
							count_q <= '0;
							fill_q  <= '0;
							st_q    <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// length register needs no reset, it is loaded on every finish
	always_ff @(posedge clk) begin
		if (msg_take && msg.opcode == OP_FINISH) begin
			len_q <= {29'd0, count_q, 3'd0};
		end else if (st_q == ST_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	sha1_sched u_sched (
		.clk   (clk),
		.ctl   (sc),
		.w_cur (w_cur)
	);

	sha1_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (rc),
		.w_cur       (w_cur),
		.word_sel    (idx_q),
		.digest_word (digest.digest_word)
	);

	// the digest is only shown once all padded blocks are folded in
	a_emit_empty_block: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q == ST_EMIT) |-> fill_q == '0)
		else $error("digest shown with a partly filled block");

	// the length field starts exactly at byte 56 of a block
	a_len_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q == ST_LEN) |-> fill_q == LEN_FILL)
		else $error("length field misplaced");

	// compression starts only when the block buffer just filled up
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q == ST_ROUND) |-> fill_q == '0 && round_q == '0)
		else $error("compression started on a partial block");

	// the last digest word returns the hasher to its initial message state
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		word_take && digest.last_word |=> st_q == ST_IDLE && count_q == '0)
		else $error("hasher not restarted after the digest");

	// the round counter stays within the 80 rounds
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= ROUND_LAST)
		else $error("round counter out of range");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// testbench for sha1_stream_hasher: byte streams and finish requests against a sha-1 predictor
`timescale 1ns / 1ps

module tb_top;
	import sha1_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned RANDOM_REQS = 80;

	// one digest word as it appears on the digest channel
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic clk = 1'b0;
	logic arst_n;

	sha1_in_if  msg_ch();
	sha1_out_if dig_ch();

	sha1_stream_hasher u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	always #5 clk = ~clk;

	// predictor state: chaining words, partial block, message length in bytes
	logic [31:0] hash_state [DIGEST_WORDS];
	logic [7:0]  pend_bytes [64];
	int unsigned pend_fill;
	logic [31:0] msg_bytes;

	// digest words still owed by the hasher, oldest first
	digest_word_t digest_expect_q [$];

	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned requests_sent = 0;

	// stimulus knobs shared between the test tasks and the digest sink
	bit msg_gaps_on = 1'b1;
	bit dig_stalls_on = 1'b1;
	int unsigned dig_hold_req = 0;

	function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < DIGEST_WORDS; i++)
			hash_state[i] = H_INIT[i];
		pend_fill = 0;
		msg_bytes = '0;
	endfunction

	// 80-round compression of the 64 pending bytes into the chaining words
	function automatic void compress_pending();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {pend_bytes[4*i], pend_bytes[4*i+1], pend_bytes[4*i+2], pend_bytes[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_2;
			end else begin
				f = b ^ c ^ d;
				k = K_3;
			end
			t = rol32(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void put_pending(input logic [7:0] v);
		pend_bytes[pend_fill] = v;
		pend_fill++;
		if (pend_fill == 64) begin
			compress_pending();
			pend_fill = 0;
		end
	endfunction

	// update the predictor for one accepted request; a finish queues five words
	function automatic void predict_request(input logic op, input logic [7:0] b);
		logic [63:0] bit_len;
		digest_word_t dw;
		if (op == OP_ABSORB) begin
			msg_bytes++;
			put_pending(b);
		end else begin
			// length field is the wrapped byte count times eight
			bit_len = {32'd0, msg_bytes} << 3;
			put_pending(PAD_MARK);
			// no room left for the length: spill into one more block
			if (pend_fill > 56)
				while (pend_fill != 0)
					put_pending(8'h00);
			while (pend_fill < 56)
				put_pending(8'h00);
			for (int i = 0; i < 8; i++)
				put_pending(bit_len[63 - 8*i -: 8]);
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				dw.word = hash_state[i];
				dw.index = 3'(i);
				dw.last = (i == DIGEST_WORDS - 1);
				digest_expect_q.push_back(dw);
			end
			restart_hash();
		end
	endfunction

	// offer one request, with random idle cycles ahead of it; returns at the
	// edge that takes it and leaves valid high for the caller
	task automatic send_request(input logic op, input logic [7:0] b);
		bit taken;
		while (msg_gaps_on && $urandom_range(99) < 14) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.opcode <= op;
		msg_ch.data_byte <= b;
		// ready is sampled mid-cycle, away from the edge
		do begin
			@(negedge clk);
			taken = msg_ch.ready;
			@(posedge clk);
		end while (!taken);
		predict_request(op, b);
		requests_sent++;
	endtask

	task automatic release_msg();
		msg_ch.valid <= 1'b0;
	endtask

	task automatic wait_digest_drained();
		while (digest_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_request(OP_ABSORB, 8'($urandom_range(255)));
		send_request(OP_FINISH, 8'($urandom_range(255)));
	endtask

	// empty message, single-byte extremes, "abc", junk data on finish
	task automatic test_short_messages();
		send_request(OP_FINISH, 8'hff);
		send_request(OP_ABSORB, 8'h00);
		send_request(OP_FINISH, 8'h00);
		send_request(OP_ABSORB, 8'hff);
		send_request(OP_FINISH, 8'h5a);
		send_request(OP_ABSORB, 8'h61);
		send_request(OP_ABSORB, 8'h62);
		send_request(OP_ABSORB, 8'h63);
		send_request(OP_FINISH, 8'ha5);
		release_msg();
		wait_digest_drained();
	endtask

	// digest side holds off while the next message is pushed in behind the
	// finish, so the message channel backs up; then the sender pauses
	task automatic test_digest_backpressure();
		dig_hold_req = HOLD_CYCLES;
		send_message(10);
		send_message(5);
		release_msg();
		wait_digest_drained();
	endtask

	// random messages, mostly short, some landing on the padding boundaries
	task automatic test_random_messages();
		int unsigned len;
		int unsigned first_req;
		int unsigned msg_cnt;
		bit saw_spill;
		bit saw_block;
		first_req = requests_sent;
		msg_cnt = 0;
		saw_spill = 1'b0;
		saw_block = 1'b0;
		while (!(requests_sent - first_req >= RANDOM_REQS && msg_cnt >= 8
			&& saw_spill && saw_block)) begin
			// the first few messages run with no idling on either side
			msg_gaps_on = (msg_cnt >= 3);
			dig_stalls_on = (msg_cnt >= 3);
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(7))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					5: len = 65;
					6: len = 119;
					default: len = 120;
				endcase
			end else begin
				len = $urandom_range(12);
			end
			if (len % 64 >= 56)
				saw_spill = 1'b1;
			if (len >= 64)
				saw_block = 1'b1;
			send_message(len);
			msg_cnt++;
		end
		msg_gaps_on = 1'b1;
		dig_stalls_on = 1'b1;
		release_msg();
	endtask

	// digest sink: drives ready at the edge, checks the word mid-cycle when
	// valid and ready are both up, i.e. the word the next edge takes
	initial begin
		int unsigned hold_left;
		digest_word_t got;
		digest_word_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (dig_hold_req != 0) begin
				hold_left = dig_hold_req;
				dig_hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				dig_ch.ready <= 1'b0;
			end else if (dig_stalls_on && $urandom_range(99) < 14) begin
				dig_ch.ready <= 1'b0;
			end else begin
				dig_ch.ready <= 1'b1;
			end
			@(negedge clk);
			if (arst_n && dig_ch.valid && dig_ch.ready) begin
				got.word = dig_ch.digest_word;
				got.index = dig_ch.word_index;
				got.last = dig_ch.last_word;
				if (digest_expect_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("unexpected digest word %h index %0d last %0b",
							got.word, got.index, got.last);
				end else begin
					want = digest_expect_q.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS)
							$display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
								want.word, want.index, want.last,
								got.word, got.index, got.last);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sha1_stream_hasher test failed");
			$finish;
		end
	end

	initial begin
		restart_hash();
		arst_n <= 1'b0;
		msg_ch.valid <= 1'b0;
		msg_ch.opcode <= OP_ABSORB;
		msg_ch.data_byte <= 8'h00;
		dig_ch.ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_messages();
		test_digest_backpressure();
		test_random_messages();

		wait_digest_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (digest_expect_q.size() != 0) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS)
				$display("%0d digest words never arrived", digest_expect_q.size());
		end
		if (fail_cnt == 0)
			$display("sha1_stream_hasher test passed");
		else
			$display("sha1_stream_hasher test failed");
		$finish;
	end

endmodule
